// ===== hdl/efp_pkg.sv =====
// ----------------------------------------------------------------------------
// efp_pkg: shared types and constants for the escape-time fractal pixel block
// Field widths, fixed-point format, colour ramp scale and register indexes.
// ----------------------------------------------------------------------------
package efp_pkg;

  // Image and arithmetic settings
  localparam int IMAGE_SIZE  = 1024;
  localparam int COLOR_SCALE = 7;
  localparam int FRAC_BITS   = 24;

  // Field widths
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int ITER_W  = 16;
  localparam int COLOR_W = 8;
  localparam int Z_W     = 32;
  localparam int PROD_W  = 2 * Z_W;
  localparam int ERQ_W   = 40;
  localparam int STEP_W  = 31;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Colour ramp: v = n * COLOR_MUL / max_iter
  localparam int COLOR_MUL  = COLOR_SCALE * 510;
  localparam int NUM_W      = ITER_W + $clog2(COLOR_MUL + 1);
  localparam int RAMP_HALF  = 255;
  localparam int RAMP_FULL  = 510;

  // Working width for sums that are saturated back to Z_W bits
  localparam int UPD_W   = PROD_W - FRAC_BITS + 3;
  localparam int COORD_W = COL_W + STEP_W + 3;
  localparam int SAT_W   = (UPD_W > COORD_W) ? UPD_W : COORD_W;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_JULIA_RE    = 3'd1,
    REG_JULIA_IM    = 3'd2,
    REG_MAX_ITER    = 3'd3,
    REG_ESCAPE_RSQ  = 3'd4,
    REG_VIEW_LEFT   = 3'd5,
    REG_VIEW_BOTTOM = 3'd6,
    REG_PIXEL_STEP  = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic               MODE_RST        = 1'b1;
  localparam logic signed [Z_W-1:0] JULIA_RE_RST = -32'sd9227469;
  localparam logic signed [Z_W-1:0] JULIA_IM_RST = 32'sd9227469;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST    = 16'd250;
  localparam logic [ERQ_W-1:0]   ESCAPE_RSQ_RST  = 40'd1677721600;
  localparam logic signed [Z_W-1:0] VIEW_LEFT_RST   = -32'sd37748736;
  localparam logic signed [Z_W-1:0] VIEW_BOTTOM_RST = -32'sd25165824;
  localparam logic [STEP_W-1:0]  PIXEL_STEP_RST  = 31'd62915;

endpackage

// ===== hdl/efp_pixel_if.sv =====
// ----------------------------------------------------------------------------
// efp_pixel_if: pixel request channel
// Valid/ready channel that carries one pixel's column and row.
// ----------------------------------------------------------------------------
interface efp_pixel_if import efp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

// ===== hdl/efp_result_if.sv =====
// ----------------------------------------------------------------------------
// efp_result_if: pixel result channel
// Valid/ready channel that carries escape count and colour of one pixel.
// ----------------------------------------------------------------------------
interface efp_result_if import efp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   pixel_column;
  logic [ROW_W-1:0]   pixel_row;
  logic               escaped;
  logic [ITER_W-1:0]  iterations;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, pixel_column, pixel_row, escaped, iterations,
                  red, green, blue, input ready);
  modport sink   (input valid, pixel_column, pixel_row, escaped, iterations,
                  red, green, blue, output ready);
endinterface

// ===== hdl/escape_time_fractal_pixel_top.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_top: Mandelbrot / Julia escape-time pixel engine
// Maps a pixel to a Q8.24 point, iterates z = z*z + c and colours the result.
// ----------------------------------------------------------------------------
// One pixel is worked at a time; in_px.ready is high only while the engine is
// free. A pixel forms its point in S_PX, S_PY and S_PINIT, then runs the first
// pass over z and each iteration in S_MRR, S_MII, S_MRI and S_EVAL, since
// every square and cross product goes through the single 32x32 multiplier;
// S_OUT hands the result to the output register. An escaped pixel also passes
// S_CNUM, S_CDIV_GO and S_CDIV for the colour ramp division. The output
// register lets the next pixel start while the previous result still waits to
// be taken. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must do this only while no pixel is in flight; it is not enforced.
module escape_time_fractal_pixel_top import efp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  efp_pixel_if.sink             in_px,
  efp_result_if.source          out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PX,
    S_PY,
    S_PINIT,
    S_MRR,
    S_MII,
    S_MRI,
    S_EVAL,
    S_CNUM,
    S_CDIV_GO,
    S_CDIV,
    S_OUT
  } state_t;

  // Configuration registers
  logic                    mode_r;
  logic signed [Z_W-1:0]   julia_re_r;
  logic signed [Z_W-1:0]   julia_im_r;
  logic [ITER_W-1:0]       max_iter_r;
  logic [ERQ_W-1:0]        erq_r;
  logic signed [Z_W-1:0]   view_left_r;
  logic signed [Z_W-1:0]   view_bottom_r;
  logic [STEP_W-1:0]       step_r;

  // Sequencer and datapath registers
  state_t                  state_r, state_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic signed [Z_W-1:0]   zr_r, zr_nxt;
  logic signed [Z_W-1:0]   zi_r, zi_nxt;
  logic signed [Z_W-1:0]   cr_r, cr_nxt;
  logic signed [Z_W-1:0]   ci_r, ci_nxt;
  logic signed [PROD_W-1:0] a_r, a_nxt;
  logic signed [PROD_W-1:0] b_r, b_nxt;
  logic [ITER_W-1:0]       iter_r, iter_nxt;
  logic                    first_r, first_nxt;
  logic                    esc_r, esc_nxt;
  logic [ITER_W-1:0]       n_r, n_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]        out_col_r, out_col_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic                    out_esc_r, out_esc_nxt;
  logic [ITER_W-1:0]       out_iter_r, out_iter_nxt;
  logic [COLOR_W-1:0]      out_red_r, out_red_nxt;
  logic [COLOR_W-1:0]      out_green_r, out_green_nxt;
  logic [COLOR_W-1:0]      out_blue_r, out_blue_nxt;

  // Shared units
  logic signed [Z_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;

  // Combinational helpers
  logic [COL_W-1:0]         col_c;
  logic [ROW_W-1:0]         row_c;
  logic signed [SAT_W-1:0]  coord_x_sum, coord_y_sum;
  logic signed [Z_W-1:0]    px, py;
  logic signed [PROD_W-1:0] sq_diff;
  logic signed [SAT_W-1:0]  zr_sum, zi_sum;
  logic signed [Z_W-1:0]    zr_upd, zi_upd;
  logic [PROD_W-1:0]        mag_sum;
  logic                     mag_hit;
  logic [COLOR_W-1:0]       ramp_red, ramp_green, ramp_blue;

  // Clamp a wide sum to the signed Q8.24 range
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
    logic signed [Z_W-1:0] res;
    if (!v[SAT_W-1] && (|v[SAT_W-2:Z_W-1])) begin
      res = {1'b0, {(Z_W-1){1'b1}}};
    end else if (v[SAT_W-1] && !(&v[SAT_W-2:Z_W-1])) begin
      res = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      res = v[Z_W-1:0];
    end
    return res;
  endfunction

  efp_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  efp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_p[NUM_W-1:0]),
    .den   (max_iter_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RST;
      julia_re_r    <= JULIA_RE_RST;
      julia_im_r    <= JULIA_IM_RST;
      max_iter_r    <= MAX_ITER_RST;
      erq_r         <= ESCAPE_RSQ_RST;
      view_left_r   <= VIEW_LEFT_RST;
      view_bottom_r <= VIEW_BOTTOM_RST;
      step_r        <= PIXEL_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode_r        <= cfg_data[0];
        REG_JULIA_RE:    julia_re_r    <= cfg_data[Z_W-1:0];
        REG_JULIA_IM:    julia_im_r    <= cfg_data[Z_W-1:0];
        REG_MAX_ITER:    max_iter_r    <= cfg_data[ITER_W-1:0];
        REG_ESCAPE_RSQ:  erq_r         <= cfg_data[ERQ_W-1:0];
        REG_VIEW_LEFT:   view_left_r   <= cfg_data[Z_W-1:0];
        REG_VIEW_BOTTOM: view_bottom_r <= cfg_data[Z_W-1:0];
        REG_PIXEL_STEP:  step_r        <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Point coordinates, z update, magnitude test and colour ramp
  always_comb begin
    col_c = (32'(col_r) >= 32'(IMAGE_SIZE)) ? COL_W'(IMAGE_SIZE - 1) : col_r;
    row_c = (32'(row_r) >= 32'(IMAGE_SIZE)) ? ROW_W'(IMAGE_SIZE - 1) : row_r;

    coord_x_sum = SAT_W'(view_left_r) + $signed(mul_p[SAT_W-1:0]);
    coord_y_sum = SAT_W'(view_bottom_r) + $signed(mul_p[SAT_W-1:0]);
    px = sat_z(coord_x_sum);
    py = sat_z(coord_y_sum);

    sq_diff = a_r - b_r;
    zr_sum  = SAT_W'($signed(sq_diff[PROD_W-1:FRAC_BITS])) + SAT_W'(cr_r);
    zi_sum  = SAT_W'($signed(mul_p[PROD_W-1:FRAC_BITS-1])) + SAT_W'(ci_r);
    zr_upd  = sat_z(zr_sum);
    zi_upd  = sat_z(zi_sum);

    mag_sum = $unsigned(a_r) + $unsigned(b_r);
    mag_hit = (mag_sum >> FRAC_BITS) > PROD_W'(erq_r);

    if (div_quo <= NUM_W'(RAMP_HALF)) begin
      ramp_red   = COLOR_W'(RAMP_HALF);
      ramp_green = COLOR_W'(NUM_W'(RAMP_HALF) - div_quo);
      ramp_blue  = '0;
    end else if (div_quo <= NUM_W'(RAMP_FULL)) begin
      ramp_red   = COLOR_W'(NUM_W'(RAMP_FULL) - div_quo);
      ramp_green = '0;
      ramp_blue  = COLOR_W'(div_quo - NUM_W'(RAMP_HALF));
    end else begin
      ramp_red   = '0;
      ramp_green = '0;
      ramp_blue  = '0;
    end
  end

  // Sequencer: next state, multiplier operands and register updates
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    iter_nxt      = iter_r;
    first_nxt     = first_r;
    esc_nxt       = esc_r;
    n_nxt         = n_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_esc_nxt   = out_esc_r;
    out_iter_nxt  = out_iter_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    mul_a         = zr_r;
    mul_b         = zr_r;
    div_start     = 1'b0;

    // Drop the held result once it is taken
    out_valid_nxt = out_valid_r && !out_res.ready;

    case (state_r)
      S_IDLE: begin
        if (in_px.valid) begin
          col_nxt   = in_px.column;
          row_nxt   = in_px.row;
          state_nxt = S_PX;
        end
      end
      S_PX: begin
        mul_a     = Z_W'(col_c) + Z_W'(1);
        mul_b     = Z_W'(step_r);
        state_nxt = S_PY;
      end
      S_PY: begin
        mul_a = Z_W'(row_c) + Z_W'(1);
        mul_b = Z_W'(step_r);
        if (mode_r) begin
          zr_nxt = '0;
          cr_nxt = px;
        end else begin
          zr_nxt = px;
          cr_nxt = julia_re_r;
        end
        state_nxt = S_PINIT;
      end
      S_PINIT: begin
        if (mode_r) begin
          zi_nxt = '0;
          ci_nxt = py;
        end else begin
          zi_nxt = py;
          ci_nxt = julia_im_r;
        end
        first_nxt = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_MRR;
      end
      S_MRR: begin
        mul_a     = zr_r;
        mul_b     = zr_r;
        state_nxt = S_MII;
      end
      S_MII: begin
        mul_a     = zi_r;
        mul_b     = zi_r;
        a_nxt     = mul_p;
        state_nxt = S_MRI;
      end
      S_MRI: begin
        mul_a     = zr_r;
        mul_b     = zi_r;
        b_nxt     = mul_p;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // Test the last update, then either stop or run the next one
        if (!first_r && mag_hit) begin
          esc_nxt   = 1'b1;
          n_nxt     = iter_r;
          state_nxt = S_CNUM;
        end else if ((!first_r && (iter_r + 1'b1 == max_iter_r)) ||
                     (first_r && (max_iter_r == '0))) begin
          esc_nxt   = 1'b0;
          n_nxt     = max_iter_r;
          state_nxt = S_OUT;
        end else begin
          zr_nxt    = zr_upd;
          zi_nxt    = zi_upd;
          iter_nxt  = first_r ? iter_r : iter_r + 1'b1;
          first_nxt = 1'b0;
          state_nxt = S_MRR;
        end
      end
      S_CNUM: begin
        mul_a     = Z_W'(n_r);
        mul_b     = Z_W'(COLOR_MUL);
        state_nxt = S_CDIV_GO;
      end
      S_CDIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_CDIV;
      end
      S_CDIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the output register when it is free or being emptied
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_esc_nxt   = esc_r;
          out_iter_nxt  = n_r;
          out_red_nxt   = esc_r ? ramp_red : '0;
          out_green_nxt = esc_r ? ramp_green : '0;
          out_blue_nxt  = esc_r ? ramp_blue : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    iter_r      <= iter_nxt;
    esc_r       <= esc_nxt;
    n_r         <= n_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_esc_r   <= out_esc_nxt;
    out_iter_r  <= out_iter_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  // Drive the channels
  assign in_px.ready          = (state_r == S_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.pixel_column = out_col_r;
  assign out_res.pixel_row    = out_row_r;
  assign out_res.escaped      = out_esc_r;
  assign out_res.iterations   = out_iter_r;
  assign out_res.red          = out_red_r;
  assign out_res.green        = out_green_r;
  assign out_res.blue         = out_blue_r;

`ifndef ASSERT_OFF
  // A new result appears only from the hand-off state
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the hand-off state");

  // A pixel that stays bounded is black
  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_esc_r) |-> (out_red_r == '0 && out_green_r == '0 &&
                                     out_blue_r == '0))
    else $error("bounded pixel carries a colour");

  // The divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_CDIV))
    else $error("divider finished outside the wait state");
`endif

endmodule

// ===== hdl/efp_mul.sv =====
// ----------------------------------------------------------------------------
// efp_mul: shared signed multiplier
// 32x32 signed product with a register on the output.
// ----------------------------------------------------------------------------
module efp_mul import efp_pkg::*; (
  input  logic                     clk,
  input  logic signed [Z_W-1:0]    mul_a,
  input  logic signed [Z_W-1:0]    mul_b,
  output logic signed [PROD_W-1:0] mul_p
);

  logic signed [PROD_W-1:0] prod_r;

  // Register the full-width product
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

// ===== hdl/efp_div.sv =====
// ----------------------------------------------------------------------------
// efp_div: radix-2 restoring divider
// Unsigned NUM_W / ITER_W division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module efp_div import efp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [ITER_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ITER_W-1:0] rem_r;
  logic [ITER_W-1:0] den_r;
  logic [NUM_W-1:0]  quo_r;

  logic [ITER_W:0]   rem_sh;
  logic [ITER_W:0]   rem_sub;
  logic              fits;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = (rem_sh >= {1'b0, den_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[ITER_W-1:0] : rem_sh[ITER_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
